// ===== rtl/gcpd_pkg.sv =====
// Package for the Gray-code pattern decoder: widths, register map, defaults
// and the result record type. No dependencies.
`timescale 1ns / 1ps

package gcpd_pkg;

    // Parameter defaults
    localparam int MAX_PIXELS_DEF    = 1048576;
    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int THRESHOLD_FRAMES  = 4;

    // Field widths
    localparam int PIX_W        = 8;
    localparam int SUM_W        = 10;   // four fringe pixels, 4*255 fits
    localparam int CODE_OUT_W   = 16;
    localparam int INDEX_OUT_W  = 20;
    localparam int TDATA_OUT_W  = 40;   // 36 payload bits, padded to bytes

    // Configuration port
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam int PIXEL_COUNT_W   = 21;
    localparam int CODE_BITS_W     = 5;
    localparam logic [APB_AW-1:0] REG_PIXEL_COUNT = 3'd0;
    localparam logic [APB_AW-1:0] REG_CODE_BITS   = 3'd4;
    localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RST = 21'd1048576;
    localparam logic [CODE_BITS_W-1:0]   CODE_BITS_RST   = 5'd10;

    // Output queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PW    = 2;
    localparam int FIFO_CW    = 2;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] pixel_index;
        logic [CODE_OUT_W-1:0]  binary_code;
        logic                   last_pixel;
    } t_result;

endpackage

// ===== rtl/gcpd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module gcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/gray_code_pattern_decoder.sv =====
// A pixel of the last Gray frame is read from memory at the accepting edge and written, with
// its update, into the output queue at the next edge. Throughput: one pixel per cycle while
// the output queue has room; the read-modify-write of each store entry is pipelined over
// the registered memory read, with forwarding for back-to-back hits on the same entry.
// Reset (synchronous, active low) clears counters, pipeline and queue and reloads the
// registers; the stores are not cleared.
`timescale 1ns / 1ps

module gray_code_pattern_decoder
    import gcpd_pkg::*;
#(
    parameter int MAX_PIXELS    = MAX_PIXELS_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input pixels
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [PIX_W-1:0]       i_s_tdata,     // [7:0] pixel_value
    // decoded pixels
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,     // [15:0] binary_code, [35:16] pixel_index
    output logic                   o_m_tlast,     // last_pixel
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int PW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int NW  = (PW + 1 > PIXEL_COUNT_W) ? PW + 1 : PIXEL_COUNT_W;
    localparam int CW  = MAX_CODE_BITS;
    localparam int FW  = $clog2(THRESHOLD_FRAMES + MAX_CODE_BITS);
    localparam int TW  = (FW + 1 > CODE_BITS_W + 1) ? FW + 1 : CODE_BITS_W + 1;

    // ---------------- configuration ----------------
    logic [PIXEL_COUNT_W-1:0] r_pixel_count;
    logic [CODE_BITS_W-1:0]   r_code_bits;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= PIXEL_COUNT_RST;
            r_code_bits   <= CODE_BITS_RST;
        end else if (cfg_wr) begin
            if (paddr == REG_PIXEL_COUNT) begin
                r_pixel_count <= pwdata[PIXEL_COUNT_W-1:0];
            end
            if (paddr == REG_CODE_BITS) begin
                r_code_bits <= pwdata[CODE_BITS_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            REG_PIXEL_COUNT: prdata = APB_DW'(r_pixel_count);
            REG_CODE_BITS:   prdata = APB_DW'(r_code_bits);
            default:         prdata = '0;
        endcase
    end

    // Registers taken saturated into their legal range
    logic [NW-1:0]          eff_pixels;
    logic [CODE_BITS_W-1:0] eff_bits;
    logic [TW-1:0]          total_frames;

    always_comb begin
        if (r_pixel_count == '0) begin
            eff_pixels = NW'(1);
        end else if (NW'(r_pixel_count) > NW'(MAX_PIXELS)) begin
            eff_pixels = NW'(MAX_PIXELS);
        end else begin
            eff_pixels = NW'(r_pixel_count);
        end
        if (r_code_bits == '0) begin
            eff_bits = CODE_BITS_W'(1);
        end else if (r_code_bits > CODE_BITS_W'(MAX_CODE_BITS)) begin
            eff_bits = CODE_BITS_W'(MAX_CODE_BITS);
        end else begin
            eff_bits = r_code_bits;
        end
        total_frames = TW'(THRESHOLD_FRAMES) + TW'(eff_bits);
    end

    // ---------------- stage 0: position counters, memory read ----------------
    logic [PW-1:0] r_pixel_counter;
    logic [FW-1:0] r_frame_counter;
    logic          in_accept;
    logic          end_frame;
    logic          end_cycle;

    assign in_accept = i_s_tvalid && o_s_tready;
    assign end_frame = (NW'(r_pixel_counter) + NW'(1)) >= eff_pixels;
    assign end_cycle = (TW'(r_frame_counter) + TW'(1)) >= total_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_counter <= '0;
            r_frame_counter <= '0;
        end else if (in_accept) begin
            if (end_frame) begin
                r_pixel_counter <= '0;
                r_frame_counter <= end_cycle ? '0 : r_frame_counter + FW'(1);
            end else begin
                r_pixel_counter <= r_pixel_counter + PW'(1);
            end
        end
    end

    // ---------------- stage 1: update and write back ----------------
    logic              r_s1_valid;
    logic [PW-1:0]     r_s1_pos;
    logic [PIX_W-1:0]  r_s1_px;
    logic              r_s1_thr;
    logic              r_s1_first;
    logic              r_s1_emit;
    logic              r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pos   <= r_pixel_counter;
            r_s1_px    <= i_s_tdata;
            r_s1_thr   <= TW'(r_frame_counter) < TW'(THRESHOLD_FRAMES);
            r_s1_first <= (TW'(r_frame_counter) == TW'(0)) ||
                          (TW'(r_frame_counter) == TW'(THRESHOLD_FRAMES));
            r_s1_emit  <= end_cycle && (TW'(r_frame_counter) >= TW'(THRESHOLD_FRAMES));
            r_s1_last  <= end_frame;
        end
    end

    logic [SUM_W-1:0] sum_q;
    logic [CW-1:0]    code_q;
    logic [SUM_W-1:0] sum_old;
    logic [CW-1:0]    code_old;
    logic [SUM_W-1:0] sum_new;
    logic [CW-1:0]    code_new;
    logic             gray_bit;
    logic             sum_we;
    logic             code_we;

    // Forwarding: a read that coincides with a write to the same entry
    logic             r_fwd_sum;
    logic             r_fwd_code;
    logic [SUM_W-1:0] r_fwd_sum_data;
    logic [CW-1:0]    r_fwd_code_data;
    logic             same_entry;

    assign sum_we     = r_s1_valid && r_s1_thr;
    assign code_we    = r_s1_valid && !r_s1_thr;
    assign same_entry = in_accept && r_s1_valid && (r_s1_pos == r_pixel_counter);

    always_comb begin
        sum_old  = r_fwd_sum ? r_fwd_sum_data : sum_q;
        code_old = r_fwd_code ? r_fwd_code_data : code_q;
        gray_bit = {r_s1_px, 2'b00} > sum_old;
        if (r_s1_first) begin
            sum_new  = SUM_W'(r_s1_px);
            code_new = CW'(gray_bit);
        end else begin
            sum_new  = sum_old + SUM_W'(r_s1_px);
            code_new = (code_old << 1) | CW'(code_old[0] ^ gray_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_sum  <= 1'b0;
            r_fwd_code <= 1'b0;
        end else begin
            r_fwd_sum  <= same_entry && r_s1_thr;
            r_fwd_code <= same_entry && !r_s1_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_sum_data  <= sum_new;
        r_fwd_code_data <= code_new;
    end

    gcpd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_PIXELS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (r_s1_pos),
        .i_wdata (sum_new),
        .i_re    (in_accept),
        .i_raddr (r_pixel_counter),
        .o_rdata (sum_q)
    );

    gcpd_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_PIXELS)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (r_s1_pos),
        .i_wdata (code_new),
        .i_re    (in_accept),
        .i_raddr (r_pixel_counter),
        .o_rdata (code_q)
    );

    // ---------------- output queue ----------------
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   r_wr_ptr;
    logic [FIFO_PW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_fifo_count;
    logic                 push;
    logic                 pop;
    t_result              head;

    assign push = r_s1_valid && r_s1_emit;
    assign pop  = o_m_tvalid && i_m_tready;

    // One slot kept free for the pixel still in stage 1
    assign o_s_tready = ((FIFO_CW + 1)'(r_fifo_count) + (FIFO_CW + 1)'(r_s1_valid))
                        < (FIFO_CW + 1)'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + FIFO_PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + FIFO_PW'(1);
            end
            if (push && !pop) begin
                r_fifo_count <= r_fifo_count + FIFO_CW'(1);
            end else if (pop && !push) begin
                r_fifo_count <= r_fifo_count - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr].binary_code <= CODE_OUT_W'(code_new);
            r_fifo[r_wr_ptr].pixel_index <= INDEX_OUT_W'(r_s1_pos);
            r_fifo[r_wr_ptr].last_pixel  <= r_s1_last;
        end
    end

    assign head       = r_fifo[r_rd_ptr];
    assign o_m_tvalid = r_fifo_count != '0;
    assign o_m_tdata  = {4'b0000, head.pixel_index, head.binary_code};
    assign o_m_tlast  = head.last_pixel;

    // ---------------- assertions ----------------
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fifo_count < FIFO_CW'(FIFO_DEPTH)) || pop)
        else $error("result pushed into a full queue");

    a_one_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sum_we && code_we))
        else $error("both stores written by one pixel");

    a_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted pixel missing from update stage");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && end_frame) |=> (r_pixel_counter == '0))
        else $error("pixel counter did not wrap at end of frame");

    a_fwd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fwd_sum && r_fwd_code))
        else $error("forwarding set for both stores");

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for gray_code_pattern_decoder: streams fringe and Gray-code frames,
// predicts every decoded pixel in step and checks the output stream and the APB registers.
// Depends on gcpd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench
    import gcpd_pkg::*;
();

    localparam int RANDOM_PIXELS = 1500;
    localparam int SETTLE_CYCLES = 8;    // results trail acceptance, keep some margin
    localparam int MAX_REPORTS   = 40;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [PIX_W-1:0]       i_s_tdata;       // [7:0] pixel_value
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_tdata;       // [15:0] binary_code, [35:16] pixel_index
    logic                   o_m_tlast;       // last_pixel
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // Mirror of the decoder state
    logic [PIXEL_COUNT_W-1:0] cfg_pixels = PIXEL_COUNT_RST;
    logic [CODE_BITS_W-1:0]   cfg_bits   = CODE_BITS_RST;
    int unsigned              pix_pos    = 0;
    int unsigned              frame_no   = 0;
    logic [SUM_W-1:0]         sum_mem  [int unsigned];
    logic [CODE_OUT_W-1:0]    code_mem [int unsigned];
    t_result                  decoded_q [$];

    int   errors      = 0;
    int   pixels_sent = 0;
    int   tx_idle_pct = 32;
    int   rx_idle_pct = 32;
    logic rx_hold     = 1'b0;

    gray_code_pattern_decoder u_top (.*);

    always #2 i_clk = ~i_clk;

    function automatic void mismatch(input string what, input longint unsigned expv,
                                     input longint unsigned got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, expv, got);
    endfunction

    // Advances the mirror by one accepted pixel and queues the decoded result, if any.
    function automatic void decode_pixel(input logic [PIX_W-1:0] px);
        int unsigned           npix;
        int unsigned           total;
        logic                  end_frame;
        logic                  end_cycle;
        logic                  gray_bit;
        logic [CODE_OUT_W-1:0] code;
        t_result               res;
        npix = (cfg_pixels == 0) ? 1 :
               (cfg_pixels > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : int'(cfg_pixels);
        total = THRESHOLD_FRAMES + ((cfg_bits == 0) ? 1 :
                (cfg_bits > MAX_CODE_BITS_DEF) ? MAX_CODE_BITS_DEF : int'(cfg_bits));
        end_frame = (pix_pos + 1 >= npix);
        end_cycle = (frame_no + 1 >= total);
        if (frame_no < THRESHOLD_FRAMES) begin
            sum_mem[pix_pos] = (frame_no == 0) ? SUM_W'(px) : SUM_W'(sum_mem[pix_pos] + px);
        end else begin
            // 4*pixel > sum is pixel > mean of the four fringe frames
            gray_bit = ({px, 2'b00} > sum_mem[pix_pos]);
            if (frame_no == THRESHOLD_FRAMES)
                code = CODE_OUT_W'(gray_bit);
            else
                code = {code_mem[pix_pos][CODE_OUT_W-2:0], code_mem[pix_pos][0] ^ gray_bit};
            code_mem[pix_pos] = code;
            if (end_cycle) begin
                res.pixel_index = INDEX_OUT_W'(pix_pos);
                res.binary_code = code;
                res.last_pixel  = end_frame;
                decoded_q.insert(decoded_q.size(), res);
            end
        end
        if (end_frame) begin
            pix_pos  = 0;
            frame_no = end_cycle ? 0 : frame_no + 1;
        end else begin
            pix_pos = pix_pos + 1;
        end
    endfunction

    // Random pixel; in Gray frames often right at the threshold.
    function automatic logic [PIX_W-1:0] pick_pixel();
        int v;
        if (frame_no >= THRESHOLD_FRAMES && $urandom_range(3) == 0) begin
            v = int'(sum_mem[pix_pos]) / 4 + int'($urandom_range(2)) - 1;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return PIX_W'(v);
        end
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        do @(posedge i_clk); while (!o_s_tready);
        decode_pixel(px);
        pixels_sent++;
    endtask

    task automatic run_to_cycle_end();
        do send_pixel(pick_pixel()); while (pix_pos != 0 || frame_no != 0);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] expv);
        logic [APB_DW-1:0] rdata;
        apb_xfer(1'b0, addr, '0, rdata);
        if (rdata !== expv)
            mismatch($sformatf("register read at %0d", addr), 64'(expv), 64'(rdata));
    endtask

    // Drains the decoder, writes a register and reads it back.
    task automatic reg_set(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rdata;
        logic [APB_DW-1:0] held;
        wait_idle();
        apb_xfer(1'b1, addr, value, rdata);
        if (addr == REG_PIXEL_COUNT) begin
            cfg_pixels = value[PIXEL_COUNT_W-1:0];
            held = APB_DW'(cfg_pixels);
        end else begin
            cfg_bits = value[CODE_BITS_W-1:0];
            held = APB_DW'(cfg_bits);
        end
        check_reg(addr, held);
    endtask

    always @(posedge i_clk) begin : rx_side
        t_result want;
        if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (decoded_q.size() == 0) begin
                mismatch("unexpected result, pixel_index", 64'(0),
                         64'(o_m_tdata[CODE_OUT_W +: INDEX_OUT_W]));
            end else begin
                want = decoded_q.pop_front();
                if (o_m_tdata[CODE_OUT_W-1:0] !== want.binary_code)
                    mismatch("binary_code", 64'(want.binary_code),
                             64'(o_m_tdata[CODE_OUT_W-1:0]));
                if (o_m_tdata[CODE_OUT_W +: INDEX_OUT_W] !== want.pixel_index)
                    mismatch("pixel_index", 64'(want.pixel_index),
                             64'(o_m_tdata[CODE_OUT_W +: INDEX_OUT_W]));
                if (o_m_tlast !== want.last_pixel)
                    mismatch("last_pixel", 64'(want.last_pixel), 64'(o_m_tlast));
            end
        end
        i_m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic test_register_defaults();
        check_reg(REG_PIXEL_COUNT, APB_DW'(PIXEL_COUNT_RST));
        check_reg(REG_CODE_BITS, APB_DW'(CODE_BITS_RST));
    endtask

    // Full-scale and zero intensities, single code bit: the first Gray frame reports.
    task automatic test_intensity_extremes();
        reg_set(REG_PIXEL_COUNT, 2);
        reg_set(REG_CODE_BITS, 1);
        repeat (THRESHOLD_FRAMES) begin
            send_pixel(8'd255);
            send_pixel(8'd0);
        end
        send_pixel(8'd255);    // equal to the mean, reads as 0
        send_pixel(8'd1);      // just above a zero mean
    endtask

    // Zero and oversize register values are taken at the nearest limit.
    task automatic test_saturated_registers();
        reg_set(REG_PIXEL_COUNT, 0);
        reg_set(REG_CODE_BITS, 0);
        run_to_cycle_end();
        reg_set(REG_PIXEL_COUNT, 1);
        reg_set(REG_CODE_BITS, 31);
        run_to_cycle_end();
    endtask

    // Largest frame size; part of a frame, then a shorter frame cuts it off.
    task automatic test_large_frame();
        reg_set(REG_PIXEL_COUNT, 32'h001F_FFFF);
        reg_set(REG_CODE_BITS, 2);
        repeat (12) send_pixel(pick_pixel());
        reg_set(REG_PIXEL_COUNT, 4);
        run_to_cycle_end();
    endtask

    // Registers change in the middle of a cycle; counters carry on.
    task automatic test_midcycle_change();
        reg_set(REG_PIXEL_COUNT, 6);
        reg_set(REG_CODE_BITS, 2);
        repeat (THRESHOLD_FRAMES * 6 + 8) send_pixel(pick_pixel());
        reg_set(REG_CODE_BITS, 4);
        repeat (7) send_pixel(pick_pixel());
        // now past the new total: the next pixel ends both frame and cycle
        reg_set(REG_PIXEL_COUNT, 3);
        reg_set(REG_CODE_BITS, 2);
        run_to_cycle_end();
    endtask

    // Receiver stalls at the start of a reporting frame while the sender keeps offering pixels.
    task automatic test_output_backpressure();
        reg_set(REG_PIXEL_COUNT, 40);
        reg_set(REG_CODE_BITS, 1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (THRESHOLD_FRAMES * 40) send_pixel(pick_pixel());
        fork
            begin
                rx_hold <= 1'b1;
                repeat (100) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        run_to_cycle_end();
        wait_idle();
        tx_idle_pct = 32;
        rx_idle_pct = 32;
    endtask

    task automatic test_random_stream();
        int unsigned first;
        int unsigned npix;
        int unsigned nbits;
        first = pixels_sent;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (pixels_sent - first < RANDOM_PIXELS) begin
            if (pixels_sent - first >= 400) begin
                tx_idle_pct = 32;
                rx_idle_pct = 32;
            end
            case ($urandom_range(9))
                0:       npix = 0;
                1:       npix = 1;
                default: npix = $urandom_range(2, 12);
            endcase
            case ($urandom_range(9))
                0:       nbits = 0;
                1:       nbits = 1;
                2:       nbits = 16;
                3:       nbits = $urandom_range(17, 31);
                default: nbits = $urandom_range(2, 15);
            endcase
            reg_set(REG_PIXEL_COUNT, npix);
            reg_set(REG_CODE_BITS, nbits);
            repeat ($urandom_range(1, 3)) run_to_cycle_end();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_intensity_extremes();
        test_saturated_registers();
        test_large_frame();
        test_midcycle_change();
        test_output_backpressure();
        test_random_stream();
        wait_idle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gcpd_pkg.sv
rtl/gcpd_ram.sv
rtl/gray_code_pattern_decoder.sv
dv/testbench.sv
